// ----- src/plb_pkg.sv -----
// ---------------------------------------------------------------------------
// plb_pkg: shared types and constants of the pixel layer blend core
// Pixel payload structs, configuration register indexes, blend mode codes,
// per-channel operation codes and the pipeline load strobes.
// ---------------------------------------------------------------------------
package plb_pkg;

    // One input transfer: a top-layer pixel and a bottom-layer pixel.
    typedef struct packed {
        logic [7:0] top_red;
        logic [7:0] top_green;
        logic [7:0] top_blue;
        logic [7:0] bottom_red;
        logic [7:0] bottom_green;
        logic [7:0] bottom_blue;
    } plb_in_t;

    // One output transfer: the blended pixel.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } plb_out_t;

    // Configuration register indexes.
    typedef logic [1:0] plb_reg_idx_t;
    localparam plb_reg_idx_t REG_BLEND_MODE  = 2'd0;
    localparam plb_reg_idx_t REG_ADD_AMOUNT  = 2'd1;
    localparam plb_reg_idx_t REG_ADD_CHANNEL = 2'd2;

    // Blend mode codes held in the blend_mode register.
    typedef logic [2:0] plb_mode_t;
    localparam plb_mode_t MODE_MULTIPLY = 3'd0;
    localparam plb_mode_t MODE_SCREEN   = 3'd1;
    localparam plb_mode_t MODE_OVERLAY  = 3'd2;
    localparam plb_mode_t MODE_SUBTRACT = 3'd3;
    localparam plb_mode_t MODE_ADD      = 3'd4;

    // Operation carried by each channel lane.
    typedef logic [2:0] plb_op_t;
    localparam plb_op_t OP_MULTIPLY = 3'd0;
    localparam plb_op_t OP_SCREEN   = 3'd1;
    localparam plb_op_t OP_OVERLAY  = 3'd2;
    localparam plb_op_t OP_SUBTRACT = 3'd3;
    localparam plb_op_t OP_ADD      = 3'd4;
    localparam plb_op_t OP_PASS     = 3'd5;

    // Rounding offset for floor(n / 255 + 1/2) = floor((n + 127) / 255).
    localparam logic [15:0] ROUND_BIAS = 16'd127;
    // 255 * 255 plus the rounding offset, for the inverted forms.
    localparam logic [15:0] FULL_SQ_BIAS = 16'd65152;

    // Load strobes for the lane pipeline registers, one per stage.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
        logic s4_load;
        logic out_load;
    } plb_load_t;

endpackage

// ----- src/plb_lane.sv -----
// ---------------------------------------------------------------------------
// plb_lane: datapath of one colour channel
// Operand selection, 8x8 multiply, inversion and rounding offset, and an
// exact division by 255, each behind its own register stage.
// ---------------------------------------------------------------------------
module plb_lane
    import plb_pkg::*;
(
    input  logic       clk,
    input  plb_load_t  load,
    input  plb_op_t    op,
    input  logic [7:0] top_val,
    input  logic [7:0] bottom_val,
    input  logic [7:0] add_amount,
    output logic [7:0] result
);

    // Stage 1: raw operands.
    plb_op_t    op1_reg;
    logic [7:0] a1_reg;
    logic [7:0] b1_reg;
    logic [7:0] amt1_reg;

    // Stage 2: multiplier operands and flags.
    logic [7:0] x2_reg;
    logic [7:0] y2_reg;
    logic       dbl2_reg;
    logic       inv2_reg;
    logic       direct2_reg;
    logic [7:0] dval2_reg;

    // Stage 3: product.
    logic [15:0] p3_reg;
    logic        dbl3_reg;
    logic        inv3_reg;
    logic        direct3_reg;
    logic [7:0]  dval3_reg;

    // Stage 4: biased numerator.
    logic [15:0] m4_reg;
    logic        direct4_reg;
    logic [7:0]  dval4_reg;

    logic [7:0] result_reg;

    logic [7:0]  x_next;
    logic [7:0]  y_next;
    logic        dbl_next;
    logic        inv_next;
    logic        direct_next;
    logic [7:0]  dval_next;
    logic [8:0]  add_sum;
    logic [15:0] n_val;
    logic [15:0] m_next;
    logic [16:0] div_sum;
    logic [7:0]  result_next;

    always_ff @(posedge clk)
    begin
        if (load.s1_load)
        begin
            op1_reg  <= op;
            a1_reg   <= top_val;
            b1_reg   <= bottom_val;
            amt1_reg <= add_amount;
        end
    end

    assign add_sum = {1'b0, a1_reg} + {1'b0, amt1_reg};

    // The inverted forms use 255 - v, which for 8 bits is the complement.
    always_comb
    begin
        x_next      = a1_reg;
        y_next      = b1_reg;
        dbl_next    = 1'b0;
        inv_next    = 1'b0;
        direct_next = 1'b0;
        dval_next   = a1_reg;
        case (op1_reg)
            OP_MULTIPLY:
            begin
                x_next = a1_reg;
                y_next = b1_reg;
            end
            OP_SCREEN:
            begin
                x_next   = ~a1_reg;
                y_next   = ~b1_reg;
                inv_next = 1'b1;
            end
            OP_OVERLAY:
            begin
                dbl_next = 1'b1;
                if (b1_reg[7])
                begin
                    x_next   = ~a1_reg;
                    y_next   = ~b1_reg;
                    inv_next = 1'b1;
                end
            end
            OP_SUBTRACT:
            begin
                direct_next = 1'b1;
                dval_next   = (a1_reg > b1_reg) ? (a1_reg - b1_reg) : 8'd0;
            end
            OP_ADD:
            begin
                direct_next = 1'b1;
                dval_next   = add_sum[8] ? 8'hFF : add_sum[7:0];
            end
            default:
            begin
                direct_next = 1'b1;
                dval_next   = a1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load.s2_load)
        begin
            x2_reg      <= x_next;
            y2_reg      <= y_next;
            dbl2_reg    <= dbl_next;
            inv2_reg    <= inv_next;
            direct2_reg <= direct_next;
            dval2_reg   <= dval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s3_load)
        begin
            p3_reg      <= x2_reg * y2_reg;
            dbl3_reg    <= dbl2_reg;
            inv3_reg    <= inv2_reg;
            direct3_reg <= direct2_reg;
            dval3_reg   <= dval2_reg;
        end
    end

    // A doubled product always comes from operands with one of them below
    // 128, so the shift cannot overflow 16 bits.
    assign n_val  = dbl3_reg ? {p3_reg[14:0], 1'b0} : p3_reg;
    assign m_next = inv3_reg ? (FULL_SQ_BIAS - n_val) : (n_val + ROUND_BIAS);

    always_ff @(posedge clk)
    begin
        if (load.s4_load)
        begin
            m4_reg      <= m_next;
            direct4_reg <= direct3_reg;
            dval4_reg   <= dval3_reg;
        end
    end

    // floor(m / 255) = (m + (m >> 8) + 1) >> 8, exact while the quotient
    // stays at or below 255.
    assign div_sum     = {1'b0, m4_reg} + {9'd0, m4_reg[15:8]} + 17'd1;
    assign result_next = direct4_reg ? dval4_reg : div_sum[15:8];

    always_ff @(posedge clk)
    begin
        if (load.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- src/pixel_layer_blend_core.sv -----
// ---------------------------------------------------------------------------
// pixel_layer_blend_core: per-pixel blend of two 8-bit RGB layers
// Top level: configuration registers, pipeline valid and flow control, and
// three channel lanes.
// ---------------------------------------------------------------------------
// The core accepts one pixel pair per clock cycle while in_stall is low and
// returns one blended pixel for each, in order. A result is presented on the
// output once it reaches the output register and leaves when the output is
// not stalled. It passes one register stage each for the operands, the
// operand select, the 8x8 multiply, the rounding offset and the division
// by 255 that feeds the output register. Every stage can hold its pixel and
// fill a bubble on its own, so a stalled output keeps taking input until all
// five stages are full. The mode, add amount and add channel registers
// should be written only while no pixel is in flight.
module pixel_layer_blend_core
    import plb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  plb_reg_idx_t cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  plb_in_t      in_data,
    output logic         out_valid,
    input  logic         out_stall,
    output plb_out_t     out_data
);

    plb_mode_t  blend_mode_reg;
    logic [7:0] add_amount_reg;
    logic [1:0] add_channel_reg;

    // Index 0 is the first stage, index 4 the output register.
    logic [4:0] valid_reg;
    logic [4:0] valid_next;
    logic [4:0] ready;

    plb_load_t  load;
    plb_op_t    lane_op [3];
    logic [7:0] top_val [3];
    logic [7:0] bottom_val [3];
    logic [7:0] lane_result [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg  <= MODE_MULTIPLY;
            add_amount_reg  <= 8'd0;
            add_channel_reg <= 2'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLEND_MODE:  blend_mode_reg  <= cfg_data[2:0];
                REG_ADD_AMOUNT:  add_amount_reg  <= cfg_data;
                REG_ADD_CHANNEL: add_channel_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        ready[4] = !valid_reg[4] || !out_stall;
        for (int i = 3; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i + 1];
        end
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < 5; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load.s1_load  = ready[0];
    assign load.s2_load  = ready[1];
    assign load.s3_load  = ready[2];
    assign load.s4_load  = ready[3];
    assign load.out_load = ready[4];

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[4];

    assign top_val[0]    = in_data.top_red;
    assign top_val[1]    = in_data.top_green;
    assign top_val[2]    = in_data.top_blue;
    assign bottom_val[0] = in_data.bottom_red;
    assign bottom_val[1] = in_data.bottom_green;
    assign bottom_val[2] = in_data.bottom_blue;

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        always_comb
        begin
            case (blend_mode_reg)
                MODE_MULTIPLY: lane_op[c] = OP_MULTIPLY;
                MODE_SCREEN:   lane_op[c] = OP_SCREEN;
                MODE_OVERLAY:  lane_op[c] = OP_OVERLAY;
                MODE_SUBTRACT: lane_op[c] = OP_SUBTRACT;
                MODE_ADD:
                    lane_op[c] = (add_channel_reg == 2'(c)) ? OP_ADD : OP_PASS;
                default:       lane_op[c] = OP_PASS;
            endcase
        end

        plb_lane u_lane (
            .clk        (clk),
            .load       (load),
            .op         (lane_op[c]),
            .top_val    (top_val[c]),
            .bottom_val (bottom_val[c]),
            .add_amount (add_amount_reg),
            .result     (lane_result[c])
        );
    end

    assign out_data.out_red   = lane_result[0];
    assign out_data.out_green = lane_result[1];
    assign out_data.out_blue  = lane_result[2];

    // Input back-pressure only ever comes from a stalled output.
    a_stall_origin : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && out_valid)
        else $error("input stalled while the output is free");

    // A result can only appear when the last internal stage held a pixel.
    a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[3]))
        else $error("output became valid without an item in the last stage");

    // Stage index 2, when full and unable to move on, keeps its pixel.
    a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && !ready[3] |=> valid_reg[2])
        else $error("a blocked pipeline stage dropped its item");

    // An accepted pixel always lands in the first stage.
    a_entry : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted pixel missing from the first stage");

endmodule

// ----- verif/tb_pixel_layer_blend_core.sv -----
// ---------------------------------------------------------------------------
// tb_pixel_layer_blend_core: self-checking bench for the pixel layer blend core
// A short table of directed pixel pairs, then about 900 random pairs over a
// series of register settings. Both channels idle and stall at random. Every
// output transfer is compared with a prediction made when its input was taken.
// ---------------------------------------------------------------------------
module tb_pixel_layer_blend_core
    import plb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY         = 5;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int PHASES          = 12;
    localparam int PHASE_ITEMS     = 75;
    localparam int IDLE_PERCENT    = 12;
    localparam int TABLE_ROWS      = 19;

    // Index with no register behind it; writes to it must change nothing.
    localparam plb_reg_idx_t REG_UNUSED = 2'd3;

    // Mode codes with no defined blend: the top pixel passes through.
    localparam plb_mode_t MODE_UNDEF_LO = 3'd5;
    localparam plb_mode_t MODE_UNDEF_HI = 3'd7;

    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;
    localparam logic [1:0] CHAN_NONE  = 2'd3;

    typedef struct packed {
        logic [7:0] mode_cfg;
        logic [7:0] amount_cfg;
        logic [7:0] chan_cfg;
        plb_in_t    pix;
        bit         typed;
        plb_out_t   want;
    } blend_case_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    plb_reg_idx_t cfg_index;
    logic [7:0]   cfg_data;
    logic         in_valid;
    logic         in_stall;
    plb_in_t      in_data;
    logic         out_valid;
    logic         out_stall;
    plb_out_t     out_data;

    // Shadow copy of the configuration registers.
    plb_mode_t  blend_mode_q;
    logic [7:0] add_amount_q;
    logic [1:0] add_channel_q;

    plb_out_t expected_pixels[$];
    plb_out_t oldest_pixel;
    int       mismatches;
    int       quiet_cycles;
    bit       hold_off_req;
    bit       quiet_stretch;

    // Rows at the reset settings come first and are run before any write.
    blend_case_t pixel_table [0:TABLE_ROWS-1] = '{
        '{{5'd0, MODE_MULTIPLY}, 8'd0, {6'd0, CHAN_RED},
          {8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd0, 8'd128}},
        '{{5'd0, MODE_MULTIPLY}, 8'd0, {6'd0, CHAN_RED},
          {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd0, 8'd0}},
        '{{5'd0, MODE_MULTIPLY}, 8'd0, {6'd0, CHAN_RED},
          {8'd1, 8'd128, 8'd200, 8'd1, 8'd127, 8'd100}, 1'b0, '0},
        '{{5'd0, MODE_SCREEN}, 8'd0, {6'd0, CHAN_RED},
          {8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b1, {8'd0, 8'd255, 8'd255}},
        '{{5'd0, MODE_SCREEN}, 8'd0, {6'd0, CHAN_RED},
          {8'd128, 8'd64, 8'd1, 8'd200, 8'd10, 8'd1}, 1'b0, '0},
        '{{5'd0, MODE_OVERLAY}, 8'd0, {6'd0, CHAN_RED},
          {8'd255, 8'd0, 8'd200, 8'd0, 8'd255, 8'd0}, 1'b1, {8'd0, 8'd255, 8'd0}},
        '{{5'd0, MODE_OVERLAY}, 8'd0, {6'd0, CHAN_RED},
          {8'd200, 8'd200, 8'd200, 8'd127, 8'd128, 8'd126}, 1'b0, '0},
        '{{5'd0, MODE_OVERLAY}, 8'd0, {6'd0, CHAN_RED},
          {8'd255, 8'd255, 8'd0, 8'd255, 8'd127, 8'd128}, 1'b0, '0},
        '{{5'd0, MODE_SUBTRACT}, 8'd0, {6'd0, CHAN_RED},
          {8'd10, 8'd255, 8'd0, 8'd20, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd255, 8'd0}},
        '{{5'd0, MODE_SUBTRACT}, 8'd0, {6'd0, CHAN_RED},
          {8'd100, 8'd255, 8'd0, 8'd100, 8'd254, 8'd255}, 1'b1, {8'd0, 8'd1, 8'd0}},
        '{{5'd0, MODE_ADD}, 8'd255, {6'd0, CHAN_RED},
          {8'd1, 8'd2, 8'd3, 8'd9, 8'd9, 8'd9}, 1'b1, {8'd255, 8'd2, 8'd3}},
        '{{5'd0, MODE_ADD}, 8'd0, {6'd0, CHAN_GREEN},
          {8'd1, 8'd2, 8'd3, 8'd255, 8'd255, 8'd255}, 1'b1, {8'd1, 8'd2, 8'd3}},
        '{{5'd0, MODE_ADD}, 8'd10, {6'd0, CHAN_BLUE},
          {8'd250, 8'd250, 8'd245, 8'd0, 8'd0, 8'd0}, 1'b1, {8'd250, 8'd250, 8'd255}},
        '{{5'd0, MODE_ADD}, 8'd10, {6'd0, CHAN_BLUE},
          {8'd250, 8'd250, 8'd246, 8'd0, 8'd0, 8'd0}, 1'b1, {8'd250, 8'd250, 8'd255}},
        '{{5'd0, MODE_ADD}, 8'd200, {6'd0, CHAN_NONE},
          {8'd17, 8'd34, 8'd51, 8'd1, 8'd2, 8'd3}, 1'b1, {8'd17, 8'd34, 8'd51}},
        '{{5'd0, MODE_UNDEF_LO}, 8'd200, {6'd0, CHAN_NONE},
          {8'd12, 8'd34, 8'd56, 8'd255, 8'd255, 8'd255}, 1'b1, {8'd12, 8'd34, 8'd56}},
        '{{5'd0, MODE_UNDEF_HI}, 8'd200, {6'd0, CHAN_NONE},
          {8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b1, {8'd255, 8'd0, 8'd255}},
        // Upper data bits set: only the low bits of each register may count.
        '{{5'b11111, MODE_ADD}, 8'hAA, {6'b111111, CHAN_GREEN},
          {8'd0, 8'd100, 8'd255, 8'd7, 8'd7, 8'd7}, 1'b0, '0},
        '{{5'b11111, MODE_MULTIPLY}, 8'h55, {6'b101010, CHAN_BLUE},
          {8'd170, 8'd85, 8'd255, 8'd85, 8'd170, 8'd255}, 1'b0, '0}
    };

    pixel_layer_blend_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // floor(n / 255 + 1/2) in exact integer form.
    function automatic logic [7:0] round_div255(input int unsigned n);
        return 8'((2 * n + 255) / 510);
    endfunction

    function automatic logic [7:0] blend_lane(input logic [7:0] a, input logic [7:0] b,
                                              input plb_mode_t mode);
        int unsigned ua;
        int unsigned ub;
        int unsigned inv;
        ua  = a;
        ub  = b;
        inv = (255 - ua) * (255 - ub);
        case (mode)
            MODE_MULTIPLY: return round_div255(ua * ub);
            MODE_SCREEN:   return round_div255(65025 - inv);
            MODE_OVERLAY:  return (ub <= 127) ? round_div255(2 * ua * ub)
                                              : round_div255(65025 - 2 * inv);
            MODE_SUBTRACT: return (ua > ub) ? 8'(ua - ub) : 8'd0;
            default:       return a;
        endcase
    endfunction

    function automatic plb_out_t blend_pixel(input plb_in_t px);
        logic [7:0]  top [3];
        logic [7:0]  bottom [3];
        logic [7:0]  mixed [3];
        int unsigned sum;
        top    = '{px.top_red, px.top_green, px.top_blue};
        bottom = '{px.bottom_red, px.bottom_green, px.bottom_blue};
        for (int c = 0; c < 3; c++)
        begin
            if (blend_mode_q == MODE_ADD)
            begin
                mixed[c] = top[c];
                if (c == int'(add_channel_q))
                begin
                    sum      = int'(top[c]) + int'(add_amount_q);
                    mixed[c] = (sum > 255) ? 8'd255 : 8'(sum);
                end
            end
            else
            begin
                mixed[c] = blend_lane(top[c], bottom[c], blend_mode_q);
            end
        end
        return '{mixed[0], mixed[1], mixed[2]};
    endfunction

    // Mostly uniform, with a bias towards the corners of the range.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(5))
                0:       return 8'd0;
                1:       return 8'd1;
                2:       return 8'd127;
                3:       return 8'd128;
                4:       return 8'd254;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic write_reg(input plb_reg_idx_t idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_BLEND_MODE:  blend_mode_q  = value[2:0];
            REG_ADD_AMOUNT:  add_amount_q  = value;
            REG_ADD_CHANNEL: add_channel_q = value[1:0];
            default: ;
        endcase
    endtask

    // Stop offering pixels and wait until every blended pixel has come back.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic program_regs(input logic [7:0] mode_cfg, input logic [7:0] amount_cfg,
                                input logic [7:0] chan_cfg);
        drain_pipeline();
        write_reg(REG_BLEND_MODE, mode_cfg);
        write_reg(REG_ADD_AMOUNT, amount_cfg);
        write_reg(REG_ADD_CHANNEL, chan_cfg);
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one pixel pair and records what should come out for it once the
    // transfer has happened.
    task automatic send_pixel(input plb_in_t px, input bit typed, input plb_out_t want);
        if (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        expected_pixels.insert(expected_pixels.size(), typed ? want : blend_pixel(px));
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] mode_cfg;
        logic [7:0] amount_cfg;
        logic [7:0] chan_cfg;
        plb_mode_t  phase_modes [5];
        plb_in_t    px;

        phase_modes   = '{MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY, MODE_SUBTRACT, MODE_ADD};
        mismatches    = 0;
        hold_off_req  = 1'b0;
        quiet_stretch = 1'b0;
        blend_mode_q  = MODE_MULTIPLY;
        add_amount_q  = 8'd0;
        add_channel_q = CHAN_RED;
        mode_cfg      = 8'd0;
        amount_cfg    = 8'd0;
        chan_cfg      = 8'd0;

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_BLEND_MODE;
        cfg_data  <= 8'd0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < TABLE_ROWS; row++)
        begin
            if (pixel_table[row].mode_cfg != mode_cfg
                || pixel_table[row].amount_cfg != amount_cfg
                || pixel_table[row].chan_cfg != chan_cfg)
            begin
                mode_cfg   = pixel_table[row].mode_cfg;
                amount_cfg = pixel_table[row].amount_cfg;
                chan_cfg   = pixel_table[row].chan_cfg;
                program_regs(mode_cfg, amount_cfg, chan_cfg);
            end
            send_pixel(pixel_table[row].pix, pixel_table[row].typed, pixel_table[row].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            mode_cfg   = 8'($urandom);
            chan_cfg   = 8'($urandom);
            amount_cfg = 8'($urandom);
            if (phase < 10)
                mode_cfg[2:0] = phase_modes[phase % 5];
            else
                mode_cfg[2:0] = 3'($urandom_range(MODE_UNDEF_HI, MODE_UNDEF_LO));
            chan_cfg[1:0] = 2'($urandom_range(CHAN_NONE, CHAN_RED));
            program_regs(mode_cfg, amount_cfg, chan_cfg);
            quiet_stretch = (phase == 6);
            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                // The output is held off here while pixels keep coming, so
                // the pipeline fills and pushes back on the input.
                if (phase == 2 && item == 10)
                    hold_off_req = 1'b1;
                px = {pick_byte(), pick_byte(), pick_byte(),
                      pick_byte(), pick_byte(), pick_byte()};
                send_pixel(px, 1'b0, '0);
            end
        end
        quiet_stretch = 1'b0;

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : receiver
        int unsigned span;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_stall    <= 1'b1;
                span         = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT)
            begin
                out_stall <= 1'b1;
                span      = $urandom_range(1, 8);
            end
            else
            begin
                out_stall <= 1'b0;
                span      = 1;
            end
            repeat (span) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("out transfer with no pixel pending: %h", out_data);
                    mismatches++;
                end
                else
                begin
                    oldest_pixel = expected_pixels.pop_front();
                    compare_field("out_red", oldest_pixel.out_red, out_data.out_red);
                    compare_field("out_green", oldest_pixel.out_green, out_data.out_green);
                    compare_field("out_blue", oldest_pixel.out_blue, out_data.out_blue);
                end
            end

            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
        else
        begin
            quiet_cycles = 0;
        end
    end

endmodule
